FILE: hw/rtl/incircle_sign_top_assert.svh
// Assertion macros for the incircle sign pipeline.
// Included by the modules that check their own logic; no other dependencies.
`ifndef INCIRCLE_SIGN_TOP_ASSERT_SVH
`define INCIRCLE_SIGN_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ICS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("incircle sign: same-cycle check failed");
// Next-cycle implication
`define ICS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("incircle sign: next-cycle check failed");
`else
`define ICS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ICS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/ics_pkg.sv
// Shared widths, types and result codes for the incircle sign pipeline.
// No dependencies; every module of the block imports it.
package ics_pkg;

    // Coordinate width; all internal widths follow from it
    localparam int COORD_BITS = 32;
    localparam int FIELD_BITS = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int MINOR_BITS = PROD_BITS + 1;
    // split of a minor or lift into halves for the wide products
    localparam int LO_BITS    = (MINOR_BITS + 1) / 2;
    localparam int HI_BITS    = MINOR_BITS - LO_BITS;
    localparam int CROSS_BITS = LO_BITS + HI_BITS + 1;
    localparam int WIDE_BITS  = 2 * MINOR_BITS;
    localparam int DET_BITS   = WIDE_BITS + 2;
    localparam int LANES      = 3;

    typedef logic signed [FIELD_BITS-1:0]   t_field;
    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic signed [DIFF_BITS-1:0]    t_diff;
    typedef logic signed [PROD_BITS-1:0]    t_prod;
    typedef logic signed [MINOR_BITS-1:0]   t_minor;
    typedef logic        [LO_BITS-1:0]      t_lo;
    typedef logic signed [HI_BITS-1:0]      t_hi;
    typedef logic        [2*LO_BITS-1:0]    t_ll;
    typedef logic signed [CROSS_BITS-1:0]   t_cross;
    typedef logic signed [CROSS_BITS:0]     t_xsum;
    typedef logic signed [2*HI_BITS-1:0]    t_hh;
    typedef logic signed [WIDE_BITS-1:0]    t_wide;
    typedef logic signed [DET_BITS-1:0]     t_det;
    typedef logic signed [1:0]              t_side;

    // Differences of a, b, c to the query point d
    typedef struct packed {
        t_diff adx;
        t_diff ady;
        t_diff bdx;
        t_diff bdy;
        t_diff cdx;
        t_diff cdy;
    } t_diffs;

    // Result codes
    localparam t_side SIDE_ON  = 2'sb00;
    localparam t_side SIDE_IN  = 2'sb01;
    localparam t_side SIDE_OUT = 2'sb11;

endpackage

FILE: hw/rtl/ics_delta.sv
// Stage 1 of the incircle sign pipeline: coordinate differences to d.
// Depends on ics_pkg.
module ics_delta (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ics_pkg::t_field i_a_x,
    input  ics_pkg::t_field i_a_y,
    input  ics_pkg::t_field i_b_x,
    input  ics_pkg::t_field i_b_y,
    input  ics_pkg::t_field i_c_x,
    input  ics_pkg::t_field i_c_y,
    input  ics_pkg::t_field i_d_x,
    input  ics_pkg::t_field i_d_y,
    output logic            o_valid,
    input  logic            i_stall,
    output ics_pkg::t_diffs o_diffs
);
    import ics_pkg::*;

    logic   r_v;
    t_diffs r_diffs;
    t_diffs n_diffs;

    // Low coordinate bits, sign-extended, then subtracted
    function automatic t_diff diff_of(t_field p, t_field q);
        t_coord pc;
        t_coord qc;
        pc = p[COORD_BITS-1:0];
        qc = q[COORD_BITS-1:0];
        return t_diff'(pc) - t_diff'(qc);
    endfunction

    always_comb begin
        n_diffs.adx = diff_of(i_a_x, i_d_x);
        n_diffs.ady = diff_of(i_a_y, i_d_y);
        n_diffs.bdx = diff_of(i_b_x, i_d_x);
        n_diffs.bdy = diff_of(i_b_y, i_d_y);
        n_diffs.cdx = diff_of(i_c_x, i_d_x);
        n_diffs.cdy = diff_of(i_c_y, i_d_y);
    end

    // Stage holds only when full and the next stage holds
    assign o_stall = r_v && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_diffs <= n_diffs;
        end
    end

    assign o_valid = r_v;
    assign o_diffs = r_diffs;

endmodule

FILE: hw/rtl/ics_minor.sv
// Stages 2 and 3: difference products, then 2x2 minors and lifted norms.
// Depends on ics_pkg.
module ics_minor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ics_pkg::t_diffs i_diffs,
    output logic            o_valid,
    input  logic            i_stall,
    output ics_pkg::t_minor o_minor [ics_pkg::LANES],
    output ics_pkg::t_minor o_lift  [ics_pkg::LANES]
);
    import ics_pkg::*;

    logic   r_v2;
    logic   r_v3;
    logic   stall2;
    logic   stall3;
    // products for the minors
    t_prod  r_adbd;
    t_prod  r_bdad;
    t_prod  r_bdcd;
    t_prod  r_cdbd;
    t_prod  r_cdad;
    t_prod  r_adcd;
    // squares for the lifts
    t_prod  r_sq_ax;
    t_prod  r_sq_ay;
    t_prod  r_sq_bx;
    t_prod  r_sq_by;
    t_prod  r_sq_cx;
    t_prod  r_sq_cy;
    t_minor r_minor [LANES];
    t_minor r_lift  [LANES];
    t_minor n_minor [LANES];
    t_minor n_lift  [LANES];

    function automatic t_prod mul_d(t_diff x, t_diff y);
        return t_prod'(x) * t_prod'(y);
    endfunction

    assign stall3  = r_v3 && i_stall;
    assign stall2  = r_v2 && stall3;
    assign o_stall = stall2;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!stall2) begin
                r_v2 <= i_valid;
            end
            if (!stall3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 2: twelve 33x33 products
    always_ff @(posedge i_clk) begin
        if (!stall2 && i_valid) begin
            r_adbd  <= mul_d(i_diffs.adx, i_diffs.bdy);
            r_bdad  <= mul_d(i_diffs.bdx, i_diffs.ady);
            r_bdcd  <= mul_d(i_diffs.bdx, i_diffs.cdy);
            r_cdbd  <= mul_d(i_diffs.cdx, i_diffs.bdy);
            r_cdad  <= mul_d(i_diffs.cdx, i_diffs.ady);
            r_adcd  <= mul_d(i_diffs.adx, i_diffs.cdy);
            r_sq_ax <= mul_d(i_diffs.adx, i_diffs.adx);
            r_sq_ay <= mul_d(i_diffs.ady, i_diffs.ady);
            r_sq_bx <= mul_d(i_diffs.bdx, i_diffs.bdx);
            r_sq_by <= mul_d(i_diffs.bdy, i_diffs.bdy);
            r_sq_cx <= mul_d(i_diffs.cdx, i_diffs.cdx);
            r_sq_cy <= mul_d(i_diffs.cdy, i_diffs.cdy);
        end
    end

    // Stage 3: lane 0 pairs bc with a's lift, lane 1 ca with b's, lane 2 ab with c's
    always_comb begin
        n_minor[0] = t_minor'(r_bdcd) - t_minor'(r_cdbd);
        n_minor[1] = t_minor'(r_cdad) - t_minor'(r_adcd);
        n_minor[2] = t_minor'(r_adbd) - t_minor'(r_bdad);
        n_lift[0]  = t_minor'(r_sq_ax) + t_minor'(r_sq_ay);
        n_lift[1]  = t_minor'(r_sq_bx) + t_minor'(r_sq_by);
        n_lift[2]  = t_minor'(r_sq_cx) + t_minor'(r_sq_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!stall3 && r_v2) begin
            r_minor <= n_minor;
            r_lift  <= n_lift;
        end
    end

    assign o_valid = r_v3;
    assign o_minor = r_minor;
    assign o_lift  = r_lift;

endmodule

FILE: hw/rtl/ics_wmul.sv
// Stages 4 and 5: lift times minor on three lanes, split into half products.
// Depends on ics_pkg.
module ics_wmul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ics_pkg::t_minor i_minor [ics_pkg::LANES],
    input  ics_pkg::t_minor i_lift  [ics_pkg::LANES],
    output logic            o_valid,
    input  logic            i_stall,
    output ics_pkg::t_wide  o_prod  [ics_pkg::LANES]
);
    import ics_pkg::*;

    logic   r_v4;
    logic   r_v5;
    logic   stall4;
    logic   stall5;
    t_lo    lift_lo  [LANES];
    t_hi    lift_hi  [LANES];
    t_lo    minor_lo [LANES];
    t_hi    minor_hi [LANES];
    t_ll    n_ll [LANES];
    t_cross n_lh [LANES];
    t_cross n_hl [LANES];
    t_hh    n_hh [LANES];
    t_ll    r_ll [LANES];
    t_cross r_lh [LANES];
    t_cross r_hl [LANES];
    t_hh    r_hh [LANES];
    t_xsum  xsum [LANES];
    t_wide  n_prod [LANES];
    t_wide  r_prod [LANES];

    assign stall5  = r_v5 && i_stall;
    assign stall4  = r_v4 && stall5;
    assign o_stall = stall4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (!stall4) begin
                r_v4 <= i_valid;
            end
            if (!stall5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 4: four half-width partial products per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lift_lo[l]  = i_lift[l][LO_BITS-1:0];
            lift_hi[l]  = i_lift[l][MINOR_BITS-1:LO_BITS];
            minor_lo[l] = i_minor[l][LO_BITS-1:0];
            minor_hi[l] = i_minor[l][MINOR_BITS-1:LO_BITS];
            n_ll[l] = t_ll'(lift_lo[l]) * t_ll'(minor_lo[l]);
            n_lh[l] = t_cross'(signed'({1'b0, lift_lo[l]})) * t_cross'(minor_hi[l]);
            n_hl[l] = t_cross'(lift_hi[l]) * t_cross'(signed'({1'b0, minor_lo[l]}));
            n_hh[l] = t_hh'(lift_hi[l]) * t_hh'(minor_hi[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall4 && i_valid) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_hh <= n_hh;
        end
    end

    // Stage 5: high and low halves abut; the cross terms add in at LO_BITS
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            xsum[l]   = t_xsum'(r_lh[l]) + t_xsum'(r_hl[l]);
            n_prod[l] = t_wide'({r_hh[l], r_ll[l]}) + (t_wide'(xsum[l]) <<< LO_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall5 && r_v4) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v5;
    assign o_prod  = r_prod;

endmodule

FILE: hw/rtl/ics_sign.sv
// Stages 6 and 7: sum of the three lane products, then its sign code.
// Depends on ics_pkg and the assertion macros header.
`include "incircle_sign_top_assert.svh"

module ics_sign (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ics_pkg::t_wide i_prod [ics_pkg::LANES],
    output logic           o_valid,
    input  logic           i_stall,
    output ics_pkg::t_side o_side
);
    import ics_pkg::*;

    logic  r_v6;
    logic  r_v7;
    logic  stall6;
    logic  stall7;
    t_det  r_det;
    t_det  n_det;
    t_side r_side;
    t_side n_side;

    assign stall7  = r_v7 && i_stall;
    assign stall6  = r_v6 && stall7;
    assign o_stall = stall6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (!stall6) begin
                r_v6 <= i_valid;
            end
            if (!stall7) begin
                r_v7 <= r_v6;
            end
        end
    end

    // Stage 6: determinant
    assign n_det = t_det'(i_prod[0]) + t_det'(i_prod[1]) + t_det'(i_prod[2]);

    always_ff @(posedge i_clk) begin
        if (!stall6 && i_valid) begin
            r_det <= n_det;
        end
    end

    // Stage 7: sign and zero test
    always_comb begin
        if (r_det[DET_BITS-1]) begin
            n_side = SIDE_OUT;
        end else if (r_det != '0) begin
            n_side = SIDE_IN;
        end else begin
            n_side = SIDE_ON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall7 && r_v6) begin
            r_side <= n_side;
        end
    end

    assign o_valid = r_v7;
    assign o_side  = r_side;

    `ICS_ASSERT_NEXT(a_zero_on, i_clk, i_rst_n, r_v6 && !stall7 && r_det == '0, o_side == SIDE_ON)
    `ICS_ASSERT_NEXT(a_neg_out, i_clk, i_rst_n, r_v6 && !stall7 && r_det[DET_BITS-1], o_side == SIDE_OUT)

endmodule

FILE: hw/rtl/incircle_sign_top.sv
// Channel   Dir  Handshake           Payload
// request   in   i_valid / o_stall   i_a_x .. i_d_y, 32-bit signed each
// result    out  o_valid / i_stall   o_side, 2-bit signed (1 in, 0 on, -1 out)
//
// One request per cycle, unless o_stall holds it, through 7 register stages (differences,
// products, minors and lifts, half products, lane products, determinant, sign);
// o_valid is the valid bit of the sign stage.
// Reset (synchronous, active low) clears the valid bits only.
// A stage holds only while full and its successor holds, so bubbles close up
// under a stall and o_stall rises only when the result register is held.
// Depends on ics_pkg, ics_delta, ics_minor, ics_wmul, ics_sign.
`include "incircle_sign_top_assert.svh"

module incircle_sign_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ics_pkg::t_field i_a_x,
    input  ics_pkg::t_field i_a_y,
    input  ics_pkg::t_field i_b_x,
    input  ics_pkg::t_field i_b_y,
    input  ics_pkg::t_field i_c_x,
    input  ics_pkg::t_field i_c_y,
    input  ics_pkg::t_field i_d_x,
    input  ics_pkg::t_field i_d_y,
    output logic            o_valid,
    input  logic            i_stall,
    output ics_pkg::t_side  o_side
);
    import ics_pkg::*;

    logic   dl_valid;
    logic   dl_stall;
    t_diffs dl_diffs;
    logic   mn_valid;
    logic   mn_stall;
    t_minor mn_minor [LANES];
    t_minor mn_lift  [LANES];
    logic   wm_valid;
    logic   wm_stall;
    t_wide  wm_prod  [LANES];
    logic   sg_stall;
    logic   side_ok;

    // Differences to d
    ics_delta u_delta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_c_x   (i_c_x),
        .i_c_y   (i_c_y),
        .i_d_x   (i_d_x),
        .i_d_y   (i_d_y),
        .o_valid (dl_valid),
        .i_stall (dl_stall),
        .o_diffs (dl_diffs)
    );

    // Minors and lifts
    ics_minor u_minor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dl_valid),
        .o_stall (dl_stall),
        .i_diffs (dl_diffs),
        .o_valid (mn_valid),
        .i_stall (mn_stall),
        .o_minor (mn_minor),
        .o_lift  (mn_lift)
    );

    // Wide lane products
    ics_wmul u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mn_valid),
        .o_stall (mn_stall),
        .i_minor (mn_minor),
        .i_lift  (mn_lift),
        .o_valid (wm_valid),
        .i_stall (wm_stall),
        .o_prod  (wm_prod)
    );

    // Determinant and sign
    ics_sign u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wm_valid),
        .o_stall (sg_stall),
        .i_prod  (wm_prod),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_side  (o_side)
    );

    assign wm_stall = sg_stall;

    // Legal side codes
    assign side_ok = (o_side == SIDE_IN) || (o_side == SIDE_ON) || (o_side == SIDE_OUT);

    `ICS_ASSERT_IMPL(a_side_code, i_clk, i_rst_n, o_valid, side_ok)
    `ICS_ASSERT_IMPL(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule
